FILE: rtl/core/bcfr_pkg.sv
package bcfr_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_IDLE_STEPS = 2'd0;
  localparam logic [1:0] CFG_MAX_STEPS  = 2'd1;
  localparam logic [1:0] CFG_LOSS_THR   = 2'd2;

  localparam logic signed [15:0] IDLE_STEPS_RST = 16'sd0;
  localparam logic signed [15:0] MAX_STEPS_RST  = 16'sd1000;
  localparam logic [15:0]        LOSS_THR_RST   = 16'd500;

  // Result action codes.
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_TARGET = 2'd1;
  localparam logic [1:0] ACT_CALIB  = 2'd2;

  // Frame characters and value limits.
  localparam logic [7:0] CH_T    = 8'h54;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [6:0] VAL_LIN_LO = 7'd32;
  localparam logic [6:0] VAL_MAX    = 7'd63;
  localparam logic [6:0] VAL_CAP    = 7'd64;

  localparam logic [15:0] MS_PER_TICK = 16'd2;
  localparam logic [15:0] MS_SAT      = 16'hFFFF;

  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_LETTER,
    PH_DIGITS,
    PH_OK,
    PH_FAIL
  } phase_t;

  typedef enum logic [1:0] {
    MAP_IDLE,
    MAP_LINEAR,
    MAP_MAX
  } map_sel_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       buffer_end;
    logic       skater_present;
  } in_t;

  typedef struct packed {
    logic [1:0]        action;
    logic signed [15:0] target_steps;
    logic              comms_lost;
  } out_t;

  // Classified command handed from the parser side to the output side.
  typedef struct packed {
    logic [1:0] action;
    map_sel_t   map_sel;
    logic [4:0] offset;
    logic       comms_lost;
  } cmd_t;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic phase_t next_phase(input phase_t ph, input logic [7:0] b,
                                        input logic [7:0] letter);
    phase_t n;
    n = ph;
    case (ph)
      PH_SEARCH: begin
        n = (b == letter) ? PH_LETTER : PH_SEARCH;
      end
      PH_LETTER: begin
        if (is_digit(b)) n = PH_DIGITS;
        else n = (b == letter) ? PH_LETTER : PH_SEARCH;
      end
      PH_DIGITS: begin
        if (is_digit(b)) n = PH_DIGITS;
        else n = (b == CH_E) ? PH_OK : PH_FAIL;
      end
      PH_OK: begin
        n = PH_OK;
      end
      default: begin
        n = PH_FAIL;
      end
    endcase
    next_phase = n;
  endfunction

endpackage

FILE: rtl/core/brake_command_frame_receiver.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    bcfr_pkg::in_t (byte or tick)
// out_      output     out_valid / out_ready  bcfr_pkg::out_t (one per tick or last byte)
// cfg_      input      cfg_we                 cfg_idx selects, cfg_wdata 16 bits
//
// One item is accepted every cycle while the command queue has room; the parsers and
// the timer update on each accepted item. A result passes the command queue, the
// multiply stage and the output register, in that order.
// The two-entry command queue decouples the parsers from the output side, so in_ready
// drops only while the queue is full under output stall.
// Reset is synchronous and active low; no clearing pass is needed.
module brake_command_frame_receiver (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bcfr_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bcfr_pkg::out_t  out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [15:0]     cfg_wdata
);

  logic signed [15:0] idle_steps_r, idle_steps_nxt, max_steps_r, max_steps_nxt;
  logic [15:0]        loss_thr_r, loss_thr_nxt;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  bcfr_pkg::cmd_t     push_data, pop_data;

  always_comb begin
    idle_steps_nxt = idle_steps_r;
    max_steps_nxt  = max_steps_r;
    loss_thr_nxt   = loss_thr_r;
    if (cfg_we) begin
      case (cfg_idx)
        bcfr_pkg::CFG_IDLE_STEPS: idle_steps_nxt = cfg_wdata;
        bcfr_pkg::CFG_MAX_STEPS:  max_steps_nxt  = cfg_wdata;
        bcfr_pkg::CFG_LOSS_THR:   loss_thr_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_steps_r <= bcfr_pkg::IDLE_STEPS_RST;
      max_steps_r  <= bcfr_pkg::MAX_STEPS_RST;
      loss_thr_r   <= bcfr_pkg::LOSS_THR_RST;
    end else begin
      idle_steps_r <= idle_steps_nxt;
      max_steps_r  <= max_steps_nxt;
      loss_thr_r   <= loss_thr_nxt;
    end
  end

  bcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .loss_thr   (loss_thr_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bcfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bcfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (pop_valid),
    .cmd_ready  (pop_ready),
    .cmd_data   (pop_data),
    .idle_steps (idle_steps_r),
    .max_steps  (max_steps_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // Only a joint target transaction carries a nonzero step count.
  a_target_only_on_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action != bcfr_pkg::ACT_TARGET) |-> (out_data.target_steps == '0))
    else $error("target_steps nonzero without a joint target action");

  // With an empty linear span every mapped target collapses to the idle target.
  a_flat_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.action == bcfr_pkg::ACT_TARGET && idle_steps_r == max_steps_r)
    |-> (out_data.target_steps == idle_steps_r))
    else $error("mapped target differs from idle target with a flat span");

  // A zero loss threshold reports lost comms on every result.
  a_zero_threshold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && loss_thr_r == '0) |-> out_data.comms_lost)
    else $error("comms_lost clear with a zero threshold");

endmodule

FILE: rtl/core/bcfr_front.sv
module bcfr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  bcfr_pkg::in_t    in_data,
  input  logic [15:0]      loss_thr,
  output logic             push_valid,
  input  logic             push_ready,
  output bcfr_pkg::cmd_t   push_data
);

  bcfr_pkg::phase_t t_ph_r, t_ph_nxt, c_ph_r, c_ph_nxt;
  bcfr_pkg::phase_t t_step, c_step;
  logic [6:0]  val_r, val_nxt;
  logic [15:0] el_r, el_nxt;
  logic        accept;
  logic        dig;
  logic [3:0]  digit;
  logic [9:0]  val_x10;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign dig      = bcfr_pkg::is_digit(in_data.rx_byte);
  assign digit    = 4'(in_data.rx_byte - bcfr_pkg::CH_ZERO);
  assign t_step   = bcfr_pkg::next_phase(t_ph_r, in_data.rx_byte, bcfr_pkg::CH_T);
  assign c_step   = bcfr_pkg::next_phase(c_ph_r, in_data.rx_byte, bcfr_pkg::CH_C);
  assign val_x10  = ({3'b000, val_r} << 3) + ({3'b000, val_r} << 1) + {6'd0, digit};

  // Next state of both parsers, the digit value and the millisecond timer.
  always_comb begin
    t_ph_nxt = t_ph_r;
    c_ph_nxt = c_ph_r;
    val_nxt  = val_r;
    el_nxt   = el_r;
    if (accept) begin
      if (in_data.req_type) begin
        el_nxt = (el_r >= (bcfr_pkg::MS_SAT - bcfr_pkg::MS_PER_TICK)) ?
                 bcfr_pkg::MS_SAT : el_r + bcfr_pkg::MS_PER_TICK;
      end else if (in_data.buffer_end) begin
        t_ph_nxt = bcfr_pkg::PH_SEARCH;
        c_ph_nxt = bcfr_pkg::PH_SEARCH;
        val_nxt  = '0;
        if (t_step == bcfr_pkg::PH_OK) el_nxt = '0;
      end else begin
        t_ph_nxt = t_step;
        c_ph_nxt = c_step;
        if (dig) begin
          if (t_ph_r == bcfr_pkg::PH_LETTER) begin
            val_nxt = {3'b000, digit};
          end else if (t_ph_r == bcfr_pkg::PH_DIGITS) begin
            val_nxt = (val_x10 > {3'b000, bcfr_pkg::VAL_CAP}) ?
                      bcfr_pkg::VAL_CAP : val_x10[6:0];
          end
        end
      end
    end
  end

  // Classification of ticks and buffer ends into commands.
  always_comb begin
    push_valid           = in_valid && (in_data.req_type || in_data.buffer_end);
    push_data.action     = bcfr_pkg::ACT_NONE;
    push_data.offset     = val_r[4:0];
    push_data.comms_lost = (el_nxt >= loss_thr);
    if (val_r < bcfr_pkg::VAL_LIN_LO) push_data.map_sel = bcfr_pkg::MAP_IDLE;
    else if (val_r < bcfr_pkg::VAL_MAX) push_data.map_sel = bcfr_pkg::MAP_LINEAR;
    else if (val_r == bcfr_pkg::VAL_MAX) push_data.map_sel = bcfr_pkg::MAP_MAX;
    else push_data.map_sel = bcfr_pkg::MAP_IDLE;
    if (!in_data.req_type) begin
      if (t_step == bcfr_pkg::PH_OK) begin
        if (in_data.skater_present) push_data.action = bcfr_pkg::ACT_TARGET;
      end else if (c_step == bcfr_pkg::PH_OK) begin
        push_data.action = bcfr_pkg::ACT_CALIB;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_ph_r <= bcfr_pkg::PH_SEARCH;
      c_ph_r <= bcfr_pkg::PH_SEARCH;
      val_r  <= '0;
      el_r   <= '0;
    end else begin
      t_ph_r <= t_ph_nxt;
      c_ph_r <= c_ph_nxt;
      val_r  <= val_nxt;
      el_r   <= el_nxt;
    end
  end

endmodule

FILE: rtl/core/bcfr_queue.sv
module bcfr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bcfr_pkg::cmd_t  push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bcfr_pkg::cmd_t  pop_data
);

  localparam int PW = $clog2(bcfr_pkg::QDEPTH);
  localparam int CW = $clog2(bcfr_pkg::QDEPTH + 1);

  bcfr_pkg::cmd_t mem_r [bcfr_pkg::QDEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != CW'(bcfr_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == PW'(bcfr_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == PW'(bcfr_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/core/bcfr_back.sv
module bcfr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  bcfr_pkg::cmd_t      cmd_data,
  input  logic signed [15:0]  idle_steps,
  input  logic signed [15:0]  max_steps,
  output logic                out_valid,
  input  logic                out_ready,
  output bcfr_pkg::out_t      out_data
);

  logic               s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt;
  bcfr_pkg::cmd_t     s1_cmd_r;
  logic signed [22:0] s1_prod_r;
  bcfr_pkg::out_t     out_data_r;
  logic               s1_load, out_load;
  logic signed [16:0] diff;
  logic signed [22:0] prod;
  logic signed [22:0] adj, quo;
  logic signed [17:0] lin;
  logic signed [15:0] target;

  assign out_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign s1_load   = cmd_valid && (!s1_valid_r || out_load);
  assign cmd_ready = !s1_valid_r || out_load;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    if (s1_load) s1_valid_nxt = 1'b1;
    else if (out_load) s1_valid_nxt = 1'b0;
  end

  // Stage 1: offset times span of the linear range.
  assign diff = {max_steps[15], max_steps} - {idle_steps[15], idle_steps};
  assign prod = $signed({18'd0, cmd_data.offset}) * $signed({{6{diff[16]}}, diff});

  // Stage 2: divide by 32 rounding toward zero, then add the idle target.
  assign adj = s1_prod_r + (s1_prod_r[22] ? 23'sd31 : 23'sd0);
  assign quo = adj >>> 5;
  assign lin = $signed({{2{idle_steps[15]}}, idle_steps}) + $signed(quo[17:0]);

  always_comb begin
    case (s1_cmd_r.map_sel)
      bcfr_pkg::MAP_LINEAR: target = lin[15:0];
      bcfr_pkg::MAP_MAX:    target = max_steps;
      default:              target = idle_steps;
    endcase
    if (s1_cmd_r.action != bcfr_pkg::ACT_TARGET) target = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cmd_r  <= cmd_data;
      s1_prod_r <= prod;
    end
    if (out_load) begin
      out_data_r.action       <= s1_cmd_r.action;
      out_data_r.target_steps <= target;
      out_data_r.comms_lost   <= s1_cmd_r.comms_lost;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
